@@ hw/rtl/tnrx_pkg.sv @@
// Shared types and protocol constants for the telnet receive parser.
package tnrx_pkg;

  // Telnet command bytes
  localparam logic [7:0] B_SE   = 8'd240;
  localparam logic [7:0] B_SB   = 8'd250;
  localparam logic [7:0] B_WILL = 8'd251;
  localparam logic [7:0] B_WONT = 8'd252;
  localparam logic [7:0] B_DO   = 8'd253;
  localparam logic [7:0] B_DONT = 8'd254;
  localparam logic [7:0] B_IAC  = 8'd255;

  // Option codes
  localparam logic [7:0] OPTION_BINARY = 8'd0;
  localparam logic [7:0] OPTION_ECHO   = 8'd1;
  localparam logic [7:0] OPTION_SGA    = 8'd3;
  localparam logic [7:0] OPTION_TTYPE  = 8'd24;
  localparam logic [7:0] OPTION_NAWS   = 8'd31;

  // Terminal-type subcommands
  localparam logic [7:0] TT_IS   = 8'd0;
  localparam logic [7:0] TT_SEND = 8'd1;

  // Item opcodes
  localparam logic OP_RX_BYTE = 1'b0;
  localparam logic OP_SESSION = 1'b1;

  // Result destinations
  localparam logic DEST_HOST = 1'b0;
  localparam logic DEST_NET  = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_TELNET_ENABLE = 2'd0;
  localparam logic [1:0] CFG_WINDOW_COLS   = 2'd1;
  localparam logic [1:0] CFG_WINDOW_ROWS   = 2'd2;
  localparam logic [1:0] CFG_TERMINAL_NAME = 2'd3;

  // Configuration reset values
  localparam logic        RST_TELNET_ENABLE = 1'b1;
  localparam logic [7:0]  RST_WINDOW_COLS   = 8'd80;
  localparam logic [7:0]  RST_WINDOW_ROWS   = 8'd24;
  localparam logic [31:0] RST_TERMINAL_NAME = 32'h616E_7369;

  // Longest burst of results caused by one item (session start)
  localparam int MAX_RESULTS = 18;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  typedef struct packed {
    logic       opcode;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic       dest;
    logic [7:0] out_byte;
    logic       last;
  } out_t;

endpackage

@@ hw/rtl/telnet_rx_parser_negotiator.sv @@
// Top level: telnet receive parser, option negotiator and reply sequencer.
// Usage:
//   in_valid/in_stall/in_data carry items: a network byte or a session-start
//   command. out_valid/out_stall/out_data carry result bytes, each tagged for
//   the host or the network, with last marking the final byte of an item.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write the four settings; cfg_ready
//   is always high. Write settings only while the block is idle.
// Flow:
//   An accepted item is held in the input register, decoded in a single
//   pass and loaded into the result shifter, whose head byte drives out_*.
//   The result shifter holds up to 18 bytes and sends one per cycle while
//   out_stall is low; an item with N results holds the output until all
//   are sent. Items with one result (payload bytes) flow at one per cycle
//   while out_stall is low; items with no result never wait for the output.
// Stall:
//   While the receiver stalls, the current result holds and items without
//   results keep passing; the next item with results waits in the input
//   register and in_stall stays high until the shifter frees up.
// Reset: rst_n clears parse state, option bits and both pipeline slots, and
//   loads the setting defaults (telnet on, 80x24, name "ansi").
module telnet_rx_parser_negotiator (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  tnrx_pkg::in_t     in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output tnrx_pkg::out_t    out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data
);

  // Parser state codes
  localparam logic [2:0] PS_DATA    = 3'd0;
  localparam logic [2:0] PS_IAC     = 3'd1;
  localparam logic [2:0] PS_OPT     = 3'd2;
  localparam logic [2:0] PS_SB_OPT  = 3'd3;
  localparam logic [2:0] PS_SB_DATA = 3'd4;
  localparam logic [2:0] PS_SB_IAC  = 3'd5;

  localparam int NRES = tnrx_pkg::MAX_RESULTS;
  localparam int CW   = tnrx_pkg::CNT_W;

  // ---------------------------------------------------------------- settings
  logic        tel_en_r;
  logic [7:0]  win_cols_r;
  logic [7:0]  win_rows_r;
  logic [31:0] term_name_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tel_en_r    <= tnrx_pkg::RST_TELNET_ENABLE;
      win_cols_r  <= tnrx_pkg::RST_WINDOW_COLS;
      win_rows_r  <= tnrx_pkg::RST_WINDOW_ROWS;
      term_name_r <= tnrx_pkg::RST_TERMINAL_NAME;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tnrx_pkg::CFG_TELNET_ENABLE: tel_en_r    <= cfg_data[0];
        tnrx_pkg::CFG_WINDOW_COLS:   win_cols_r  <= cfg_data[7:0];
        tnrx_pkg::CFG_WINDOW_ROWS:   win_rows_r  <= cfg_data[7:0];
        tnrx_pkg::CFG_TERMINAL_NAME: term_name_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------- parser state
  logic [2:0] pstate_r, pstate_nxt;
  logic [7:0] verb_r, verb_nxt;
  logic [7:0] sub_opt_r, sub_opt_nxt;
  logic [7:0] sub_first_r, sub_first_nxt;
  logic       sub_has_r, sub_has_nxt;

  // Option bitmaps. Only options that can ever be accepted get storage; all
  // other bits of the 256-bit maps stay cleared and read as zero.
  //   remote: {SGA, ECHO, BINARY}
  //   local enabled / offered: {NAWS, TTYPE, SGA, BINARY}
  logic [2:0] rem_r, rem_nxt;
  logic [3:0] loc_r, loc_nxt;
  logic [3:0] off_r, off_nxt;

  // ---------------------------------------------------------- input register
  logic           item_vld_r;
  tnrx_pkg::in_t  item_r;
  logic           item_move;

  // ---------------------------------------------------------- result shifter
  logic [7:0]    buf_byte_r [NRES];
  logic          buf_dest_r;
  logic [CW-1:0] buf_cnt_r;
  logic          buf_take;
  logic          buf_free;

  // decoded results of the item in the input register
  logic [7:0]    res_b [NRES];
  logic          res_dest;
  logic [CW-1:0] res_cnt;

  // ---------------------------------------------------------- decode
  always_comb begin
    logic [7:0] b;
    logic [2:0] rsel;
    logic [3:0] lsel;
    logic       rem_get, loc_get, off_get;
    logic [7:0] win [9];

    b    = item_r.rx_byte;
    rsel = {b == tnrx_pkg::OPTION_SGA, b == tnrx_pkg::OPTION_ECHO,
            b == tnrx_pkg::OPTION_BINARY};
    lsel = {b == tnrx_pkg::OPTION_NAWS, b == tnrx_pkg::OPTION_TTYPE,
            b == tnrx_pkg::OPTION_SGA, b == tnrx_pkg::OPTION_BINARY};
    rem_get = |(rem_r & rsel);
    loc_get = |(loc_r & lsel);
    off_get = |(off_r & lsel);

    win[0] = tnrx_pkg::B_IAC;
    win[1] = tnrx_pkg::B_SB;
    win[2] = tnrx_pkg::OPTION_NAWS;
    win[3] = 8'd0;
    win[4] = win_cols_r;
    win[5] = 8'd0;
    win[6] = win_rows_r;
    win[7] = tnrx_pkg::B_IAC;
    win[8] = tnrx_pkg::B_SE;

    pstate_nxt    = pstate_r;
    verb_nxt      = verb_r;
    sub_opt_nxt   = sub_opt_r;
    sub_first_nxt = sub_first_r;
    sub_has_nxt   = sub_has_r;
    rem_nxt       = rem_r;
    loc_nxt       = loc_r;
    off_nxt       = off_r;
    res_dest      = tnrx_pkg::DEST_NET;
    res_cnt       = '0;
    for (int i = 0; i < NRES; i++) res_b[i] = 8'd0;

    if (item_r.opcode == tnrx_pkg::OP_SESSION) begin
      rem_nxt     = '0;
      loc_nxt     = '0;
      off_nxt     = '0;
      sub_has_nxt = 1'b0;
      pstate_nxt  = PS_DATA;
      if (tel_en_r) begin
        // all offers go out since the maps were just cleared
        off_nxt = 4'b1111;
        res_b[0]  = tnrx_pkg::B_IAC; res_b[1]  = tnrx_pkg::B_WILL;
        res_b[2]  = tnrx_pkg::OPTION_TTYPE;
        res_b[3]  = tnrx_pkg::B_IAC; res_b[4]  = tnrx_pkg::B_WILL;
        res_b[5]  = tnrx_pkg::OPTION_NAWS;
        res_b[6]  = tnrx_pkg::B_IAC; res_b[7]  = tnrx_pkg::B_WILL;
        res_b[8]  = tnrx_pkg::OPTION_SGA;
        res_b[9]  = tnrx_pkg::B_IAC; res_b[10] = tnrx_pkg::B_DO;
        res_b[11] = tnrx_pkg::OPTION_SGA;
        res_b[12] = tnrx_pkg::B_IAC; res_b[13] = tnrx_pkg::B_WILL;
        res_b[14] = tnrx_pkg::OPTION_BINARY;
        res_b[15] = tnrx_pkg::B_IAC; res_b[16] = tnrx_pkg::B_DO;
        res_b[17] = tnrx_pkg::OPTION_BINARY;
        res_cnt   = CW'(NRES);
      end
    end else if (!tel_en_r) begin
      res_dest = tnrx_pkg::DEST_HOST;
      res_b[0] = b;
      res_cnt  = CW'(1);
    end else begin
      unique case (pstate_r)
        PS_DATA: begin
          if (b == tnrx_pkg::B_IAC) begin
            pstate_nxt = PS_IAC;
          end else begin
            res_dest = tnrx_pkg::DEST_HOST;
            res_b[0] = b;
            res_cnt  = CW'(1);
          end
        end
        PS_IAC: begin
          if (b == tnrx_pkg::B_IAC) begin
            res_dest   = tnrx_pkg::DEST_HOST;
            res_b[0]   = tnrx_pkg::B_IAC;
            res_cnt    = CW'(1);
            pstate_nxt = PS_DATA;
          end else if (b == tnrx_pkg::B_WILL || b == tnrx_pkg::B_WONT ||
                       b == tnrx_pkg::B_DO || b == tnrx_pkg::B_DONT) begin
            verb_nxt   = b;
            pstate_nxt = PS_OPT;
          end else if (b == tnrx_pkg::B_SB) begin
            pstate_nxt = PS_SB_OPT;
          end else begin
            pstate_nxt = PS_DATA;   // standalone command, dropped
          end
        end
        PS_OPT: begin
          pstate_nxt = PS_DATA;
          res_b[0]   = tnrx_pkg::B_IAC;
          res_b[2]   = b;
          case (verb_r)
            tnrx_pkg::B_WILL: begin
              if (|rsel) begin
                if (!rem_get) begin
                  rem_nxt  = rem_r | rsel;
                  res_b[1] = tnrx_pkg::B_DO;
                  res_cnt  = CW'(3);
                end
              end else begin
                // refused; its remote bit is never set
                res_b[1] = tnrx_pkg::B_DONT;
                res_cnt  = CW'(3);
              end
            end
            tnrx_pkg::B_WONT: begin
              if (rem_get) begin
                rem_nxt  = rem_r & ~rsel;
                res_b[1] = tnrx_pkg::B_DONT;
                res_cnt  = CW'(3);
              end
            end
            tnrx_pkg::B_DO: begin
              if (|lsel) begin
                if (!loc_get) begin
                  loc_nxt = loc_r | lsel;
                  if (!off_get) begin
                    off_nxt  = off_r | lsel;
                    res_b[1] = tnrx_pkg::B_WILL;
                    res_cnt  = CW'(3);
                    if (b == tnrx_pkg::OPTION_NAWS) begin
                      for (int i = 0; i < 9; i++) res_b[i+3] = win[i];
                      res_cnt = CW'(12);
                    end
                  end else if (b == tnrx_pkg::OPTION_NAWS) begin
                    for (int i = 0; i < 9; i++) res_b[i] = win[i];
                    res_cnt = CW'(9);
                  end
                end
              end else begin
                res_b[1] = tnrx_pkg::B_WONT;
                res_cnt  = CW'(3);
              end
            end
            tnrx_pkg::B_DONT: begin
              if (loc_get) begin
                loc_nxt  = loc_r & ~lsel;
                res_b[1] = tnrx_pkg::B_WONT;
                res_cnt  = CW'(3);
              end
            end
            default: ;
          endcase
        end
        PS_SB_OPT: begin
          sub_opt_nxt = b;
          sub_has_nxt = 1'b0;
          pstate_nxt  = PS_SB_DATA;
        end
        PS_SB_DATA: begin
          if (b == tnrx_pkg::B_IAC) begin
            pstate_nxt = PS_SB_IAC;
          end else if (!sub_has_r) begin
            sub_first_nxt = b;
            sub_has_nxt   = 1'b1;
          end
        end
        PS_SB_IAC: begin
          if (b == tnrx_pkg::B_SE) begin
            pstate_nxt = PS_DATA;
            if (sub_opt_r == tnrx_pkg::OPTION_TTYPE && sub_has_r &&
                sub_first_r == tnrx_pkg::TT_SEND) begin
              res_b[0] = tnrx_pkg::B_IAC;
              res_b[1] = tnrx_pkg::B_SB;
              res_b[2] = tnrx_pkg::OPTION_TTYPE;
              res_b[3] = tnrx_pkg::TT_IS;
              res_b[4] = term_name_r[31:24];
              res_b[5] = term_name_r[23:16];
              res_b[6] = term_name_r[15:8];
              res_b[7] = term_name_r[7:0];
              res_b[8] = tnrx_pkg::B_IAC;
              res_b[9] = tnrx_pkg::B_SE;
              res_cnt  = CW'(10);
            end
          end else begin
            // escaped byte inside subnegotiation counts as data
            pstate_nxt = PS_SB_DATA;
            if (!sub_has_r) begin
              sub_first_nxt = b;
              sub_has_nxt   = 1'b1;
            end
          end
        end
        default: pstate_nxt = PS_DATA;
      endcase
    end
  end

  // ---------------------------------------------------------- flow control
  assign buf_take  = out_valid && !out_stall;
  assign buf_free  = (buf_cnt_r == '0) || (buf_take && buf_cnt_r == CW'(1));
  // items without results never wait on the output side
  assign item_move = item_vld_r && (buf_free || res_cnt == '0);
  assign in_stall  = item_vld_r && !item_move;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      item_vld_r <= 1'b1;
    end else if (item_move) begin
      item_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r <= in_data;
    end
  end

  // state commits when the item leaves the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pstate_r    <= PS_DATA;
      verb_r      <= 8'd0;
      sub_opt_r   <= 8'd0;
      sub_first_r <= 8'd0;
      sub_has_r   <= 1'b0;
      rem_r       <= '0;
      loc_r       <= '0;
      off_r       <= '0;
    end else if (item_move) begin
      pstate_r    <= pstate_nxt;
      verb_r      <= verb_nxt;
      sub_opt_r   <= sub_opt_nxt;
      sub_first_r <= sub_first_nxt;
      sub_has_r   <= sub_has_nxt;
      rem_r       <= rem_nxt;
      loc_r       <= loc_nxt;
      off_r       <= off_nxt;
    end
  end

  // ---------------------------------------------------------- result shifter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_cnt_r <= '0;
    end else if (item_move && res_cnt != '0) begin
      buf_cnt_r <= res_cnt;
    end else if (buf_take) begin
      buf_cnt_r <= buf_cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (item_move && res_cnt != '0) begin
      buf_dest_r <= res_dest;
      for (int i = 0; i < NRES; i++) buf_byte_r[i] <= res_b[i];
    end else if (buf_take) begin
      for (int i = 0; i < NRES - 1; i++) buf_byte_r[i] <= buf_byte_r[i+1];
      buf_byte_r[NRES-1] <= 8'd0;
    end
  end

  assign out_valid         = (buf_cnt_r != '0);
  assign out_data.dest     = buf_dest_r;
  assign out_data.out_byte = buf_byte_r[0];
  assign out_data.last     = (buf_cnt_r == CW'(1));

`ifndef NO_ASSERTIONS
  // an option is never enabled locally without having been offered
  a_loc_offered: assert property (@(posedge clk) disable iff (!rst_n)
    (loc_r & ~off_r) == 4'b0000)
    else $error("local option enabled without offer");

  // host-bound bytes are always single results
  a_host_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.dest == tnrx_pkg::DEST_HOST) |-> out_data.last)
    else $error("host byte not marked last");

  // a session start with telnet on loads the full offer burst
  a_session_burst: assert property (@(posedge clk) disable iff (!rst_n)
    (item_move && item_r.opcode == tnrx_pkg::OP_SESSION && tel_en_r)
      |=> (buf_cnt_r == CW'(NRES)))
    else $error("session offers not loaded");

  // result count stays within the shifter
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    buf_cnt_r <= CW'(NRES))
    else $error("result count overflow");
`endif

endmodule
